[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of i_clk, switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge of i_clk, including while reset is held.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/core/lssm_pkg.sv]
// Shared types and fixed widths of the divisible-sum subsequence core.
`timescale 1ns / 1ps

package lssm_pkg;

    localparam int VALUE_W = 31;                 // width of an input value
    localparam int MOD_W   = 7;                  // width of the modulus register
    localparam int OUT_W   = 11;                 // width of the reported length
    localparam int CNT_W   = $clog2(VALUE_W);    // divide step counter

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SWEEP,
        ST_DRAIN,
        ST_FIN
    } t_state;

endpackage

[rtl/core/lssm_ram.sv]
// Generic simple dual-port RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module lssm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

[rtl/core/longest_subsequence_sum_mod_k.sv]
// Top level: streaming longest subsequence whose sum is divisible by k.
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  Channel   Direction  Handshake                   Payload
//  -------   ---------  --------------------------  -----------------------
//  in        sink       i_in_valid / o_in_stall     i_value, i_last
//  out       source     o_out_valid / i_out_stall   o_best_length
//  cfg       sink       i_cfg_we                    i_cfg_wdata (modulus)
//
// Each request is accepted in the idle state and runs a bit-serial remainder,
// one divide step per bit of the value, then a sweep of all MAX_MOD table
// entries, one table entry per cycle through the shared compare/increment unit,
// a drain of the RAM read stage and a finishing step before it returns to
// idle; the next request is taken only in the idle state.
// Reset is synchronous and active low; it restores the empty table at once
// through the per-entry written flags, so there is no clearing pass.
// A stalled result waits in the output register; the next request is already taken
// in; only its finishing step, if it closes a sequence, waits until the output register is free.

module longest_subsequence_sum_mod_k
    import lssm_pkg::*;
#(
    parameter int MAX_MOD   = 64,
    parameter int MAX_ITEMS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [MOD_W-1:0]   i_cfg_wdata,
    // input requests
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_last,
    // results
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [OUT_W-1:0]   o_best_length
);

    // Index width of one table bank, width of the effective divisor, width of
    // a stored length, and the RAM holding both banks side by side.
    localparam int IW        = $clog2(MAX_MOD);
    localparam int KW        = $clog2(MAX_MOD + 1);
    localparam int CW        = (KW > MOD_W) ? KW : MOD_W;
    localparam int LW        = $clog2(MAX_ITEMS + 1);
    localparam int EW        = LW + 1;
    localparam int AW        = IW + 1;
    localparam int RAM_DEPTH = 2 ** AW;

    // Control state.
    t_state             r_state, n_state;
    logic [MOD_W-1:0]   r_modulus, n_modulus;
    logic               r_bank, n_bank;
    logic [RAM_DEPTH-1:0] r_wr, n_wr;
    logic               r_out_v, n_out_v;
    logic               r_p_v, n_p_v;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [IW-1:0]      r_j, n_j;

    // Per-request data.
    logic [KW-1:0]      r_k, n_k;
    logic [VALUE_W-1:0] r_val, n_val;
    logic [IW-1:0]      r_rem, n_rem;
    logic               r_last, n_last;
    logic [LW-1:0]      r_ans, n_ans;
    logic [OUT_W-1:0]   r_out_len, n_out_len;

    // Read stage of the sweep: what was issued to the RAM last cycle.
    logic [IW-1:0]      r_p_idx, n_p_idx;
    logic               r_p_upd, n_p_upd;
    logic               r_p_wr_dst, n_p_wr_dst;
    logic               r_p_wr_src, n_p_wr_src;
    logic               r_p_src_zero, n_p_src_zero;

    // Combinational helpers.
    logic [CW-1:0]      mod_ext;
    logic [KW-1:0]      k_eff;
    logic [AW-1:0]      k_ext;
    logic [AW-1:0]      div_t;
    logic [AW-1:0]      j_ext;
    logic               j_in_range;
    logic [AW-1:0]      src_sum;
    logic [AW-1:0]      src_wrap;
    logic [IW-1:0]      src_idx;
    logic [AW-1:0]      raddr_a, raddr_b, waddr;
    logic [EW-1:0]      rd_a, rd_b, wdata;
    logic               ram_we;
    logic               dst_v, src_v;
    logic [LW-1:0]      dst_l, src_l;
    logic [LW:0]        cand_full;
    logic [LW-1:0]      cand_l;
    logic               take;
    logic               out_free;
    logic [LW+OUT_W-1:0] ans_ext;

    // Effective divisor: zero acts as one, values above MAX_MOD saturate.
    always_comb begin
        mod_ext = CW'(r_modulus);
        if (mod_ext == '0) begin
            k_eff = KW'(1);
        end else if (mod_ext > CW'(MAX_MOD)) begin
            k_eff = KW'(MAX_MOD);
        end else begin
            k_eff = KW'(mod_ext);
        end
    end

    // Datapath helpers. During the remainder phase div_t feeds one restoring
    // divide step; during the sweep the source index (j + r) mod k is formed with
    // a single compare and subtract while both j and r are below k, else it is j.
    assign k_ext      = AW'(r_k);
    assign div_t      = {r_rem, r_val[VALUE_W-1]};
    assign j_ext      = AW'(r_j);
    assign j_in_range = (j_ext < k_ext);
    assign src_sum    = j_ext + AW'(r_rem);
    assign src_wrap   = (src_sum >= k_ext) ? (src_sum - k_ext) : src_sum;
    assign src_idx    = j_in_range ? IW'(src_wrap) : r_j;

    // Reads come from the current bank, the updated entry goes to the other
    // one, so every read sees the table as it was before this request.
    assign raddr_a = {r_bank, r_j};
    assign raddr_b = {r_bank, src_idx};
    assign waddr   = {~r_bank, r_p_idx};
    assign ram_we  = r_p_v;

    lssm_ram #(
        .WIDTH (EW),
        .DEPTH (RAM_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // An entry never written since the last clear reads as the empty table:
    // residue zero holds length zero, every other residue is unreachable.
    always_comb begin
        dst_v = r_p_wr_dst ? rd_a[LW] : (r_p_idx == '0);
        dst_l = r_p_wr_dst ? rd_a[LW-1:0] : '0;
        src_v = r_p_wr_src ? rd_b[LW] : r_p_src_zero;
        src_l = r_p_wr_src ? rd_b[LW-1:0] : '0;

        cand_full = {1'b0, src_l} + (LW+1)'(1);
        if (cand_full > (LW+1)'(MAX_ITEMS)) begin
            cand_l = LW'(MAX_ITEMS);
        end else begin
            cand_l = LW'(cand_full);
        end

        // Entries at or above k are carried over unchanged.
        take  = r_p_upd && src_v && (!dst_v || (cand_l > dst_l));
        wdata = take ? {1'b1, cand_l} : {dst_v, dst_l};
    end

    assign out_free = !r_out_v || !i_out_stall;
    assign ans_ext  = {{OUT_W{1'b0}}, r_ans};

    // Sequencer and next-state logic.
    always_comb begin
        n_state      = r_state;
        n_modulus    = r_modulus;
        n_bank       = r_bank;
        n_wr         = r_wr;
        n_out_v      = r_out_v;
        n_p_v        = 1'b0;
        n_cnt        = r_cnt;
        n_j          = r_j;
        n_k          = r_k;
        n_val        = r_val;
        n_rem        = r_rem;
        n_last       = r_last;
        n_ans        = r_ans;
        n_out_len    = r_out_len;
        n_p_idx      = r_p_idx;
        n_p_upd      = r_p_upd;
        n_p_wr_dst   = r_p_wr_dst;
        n_p_wr_src   = r_p_wr_src;
        n_p_src_zero = r_p_src_zero;

        if (i_cfg_we) begin
            n_modulus = i_cfg_wdata;
        end

        if (r_out_v && !i_out_stall) begin
            n_out_v = 1'b0;
        end

        // Write back of the read stage, and capture of the new residue zero
        // entry, which is the answer when this request closes a sequence.
        if (r_p_v) begin
            n_wr[waddr] = 1'b1;
            if (r_p_idx == '0) begin
                n_ans = wdata[LW] ? wdata[LW-1:0] : '0;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_val   = i_value;
                    n_last  = i_last;
                    n_k     = k_eff;
                    n_rem   = '0;
                    n_cnt   = CNT_W'(VALUE_W - 1);
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_t >= k_ext) begin
                    n_rem = IW'(div_t - k_ext);
                end else begin
                    n_rem = IW'(div_t);
                end
                n_val = {r_val[VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_j     = '0;
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                n_p_v        = 1'b1;
                n_p_idx      = r_j;
                n_p_upd      = j_in_range;
                n_p_wr_dst   = r_wr[raddr_a];
                n_p_wr_src   = r_wr[raddr_b];
                n_p_src_zero = (src_idx == '0);
                n_j          = r_j + IW'(1);
                if (r_j == IW'(MAX_MOD - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_last) begin
                    n_bank  = ~r_bank;
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_bank    = ~r_bank;
                    n_wr      = '0;
                    n_out_v   = 1'b1;
                    n_out_len = ans_ext[OUT_W-1:0];
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_modulus <= MOD_W'(1);
            r_bank    <= 1'b0;
            r_wr      <= '0;
            r_out_v   <= 1'b0;
            r_p_v     <= 1'b0;
            r_cnt     <= '0;
            r_j       <= '0;
        end else begin
            r_state   <= n_state;
            r_modulus <= n_modulus;
            r_bank    <= n_bank;
            r_wr      <= n_wr;
            r_out_v   <= n_out_v;
            r_p_v     <= n_p_v;
            r_cnt     <= n_cnt;
            r_j       <= n_j;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_k          <= n_k;
        r_val        <= n_val;
        r_rem        <= n_rem;
        r_last       <= n_last;
        r_ans        <= n_ans;
        r_out_len    <= n_out_len;
        r_p_idx      <= n_p_idx;
        r_p_upd      <= n_p_upd;
        r_p_wr_dst   <= n_p_wr_dst;
        r_p_wr_src   <= n_p_wr_src;
        r_p_src_zero <= n_p_src_zero;
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_v;
    assign o_best_length = r_out_len;

    // The sweep must never overwrite the bank it is reading from.
    `ASSERT_CLK(a_write_other_bank, ram_we |-> (waddr[IW] != r_bank), "write hit the read bank")
    // The remainder is fully reduced before the sweep uses it.
    `ASSERT_CLK(a_rem_reduced, (r_state == ST_SWEEP) |-> (AW'(r_rem) < k_ext), "remainder not below k")
    // The read stage is empty when the table may be cleared.
    `ASSERT_CLK(a_fin_drained, (r_state == ST_FIN) |-> !r_p_v, "write pending at finish")
    // A new result only appears from the finishing step.
    `ASSERT_CLK(a_out_from_fin, $rose(r_out_v) |-> ($past(r_state) == ST_FIN), "stray result")

endmodule
